// ===== sv/kpg_pkg.sv =====
`timescale 1ns / 1ps

package kpg_pkg;

    localparam int MAX_ITEMS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = 5;
    localparam int OP_W       = 2;
    localparam int TDATA_W    = ((IDX_W + ELEM_WIDTH + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - IDX_W - ELEM_WIDTH;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [ELEM_WIDTH-1:0] elem_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_NEXT    = 2'd2
    } op_t;

    localparam logic REG_ITEM_COUNT = 1'b0;
    localparam logic REG_PICK_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_SWP_RD_A,
        ST_SWP_RD_B,
        ST_SWP_WR_A,
        ST_SWP_WR_B,
        ST_ROT_RD0,
        ST_ROT_TMP,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_ROT_LAST,
        ST_EMIT_ORD,
        ST_EMIT_POOL,
        ST_EMIT_OUT,
        ST_DONE
    } state_t;

    // countdown start value for level e with n items taking part
    function automatic cnt_t rem_init(input cnt_t n, input int e);
        cnt_t ev;
        ev = CNT_W'(e);
        return (ev < n) ? cnt_t'(n - ev) : '0;
    endfunction

endpackage

// ===== sv/k_permutation_generator_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tdata, s_tuser = opcode
// m_       | out       | m_tvalid / m_tready  | m_tdata, m_tlast = row_last, m_tuser = done_res
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Load and restart complete on acceptance. A next after the first row runs the advance (ST_ADV
// per counter level, then a swap or a tail rotate), then ST_EMIT_ORD, ST_EMIT_POOL and ST_EMIT_OUT
// per row position, all bound by the single read port of the index memory. A done result comes from ST_DONE.
// Reset (aresetn low, synchronous) sets n=16, k=1 and the identity sequence; pool is undefined.
// s_tready is low while a transaction is in work; a stalled m_ side holds the sequencer.
module k_permutation_generator_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [kpg_pkg::TDATA_W-1:0] s_tdata,   // load_index, load_value
    input  logic [kpg_pkg::OP_W-1:0]    s_tuser,   // opcode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [kpg_pkg::TDATA_W-1:0] m_tdata,   // item_index, item_value
    output logic                        m_tlast,
    output logic                        m_tuser,   // done_res
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [kpg_pkg::CNT_W-1:0]   cfg_data
);

    kpg_pkg::state_t state_reg, state_next;

    kpg_pkg::cnt_t  item_count_reg, pick_count_reg;
    kpg_pkg::cnt_t  rem_reg  [kpg_pkg::MAX_ITEMS];
    kpg_pkg::cnt_t  rem_next [kpg_pkg::MAX_ITEMS];
    logic           first_reg, first_next;
    logic           exh_reg, exh_next;
    kpg_pkg::idx_t  i_reg, i_next;
    kpg_pkg::idx_t  j_reg, j_next;
    kpg_pkg::idx_t  p_reg, p_next;
    kpg_pkg::cnt_t  ptr_reg, ptr_next;
    kpg_pkg::idx_t  tmp_reg, tmp_next;
    kpg_pkg::idx_t  idx_reg, idx_next;

    logic           out_valid_reg, out_valid_next;
    kpg_pkg::idx_t  out_idx_reg, out_idx_next;
    kpg_pkg::elem_t out_val_reg, out_val_next;
    logic           out_last_reg, out_last_next;
    logic           out_done_reg, out_done_next;

    kpg_pkg::idx_t  ord_mem [kpg_pkg::MAX_ITEMS];
    logic [kpg_pkg::MAX_ITEMS-1:0] ord_valid_reg;
    kpg_pkg::idx_t  ord_rdata_reg;
    logic           ord_we, ord_clear;
    kpg_pkg::idx_t  ord_waddr, ord_wdata, ord_raddr;

    kpg_pkg::elem_t pool_mem [kpg_pkg::MAX_ITEMS];
    kpg_pkg::elem_t pool_rdata_reg;
    logic           pool_we, pool_re;
    kpg_pkg::idx_t  pool_raddr;

    kpg_pkg::cnt_t  n_eff, n_dec, k_dec, ptr_dec, p_plus, rem_dec;
    logic           out_free, s_accept;

    assign n_eff    = (item_count_reg > kpg_pkg::CNT_W'(kpg_pkg::MAX_ITEMS)) ?
                      kpg_pkg::CNT_W'(kpg_pkg::MAX_ITEMS) : item_count_reg;
    assign n_dec    = n_eff - kpg_pkg::CNT_W'(1);
    assign k_dec    = pick_count_reg - kpg_pkg::CNT_W'(1);
    assign ptr_dec  = ptr_reg - kpg_pkg::CNT_W'(1);
    assign p_plus   = {1'b0, p_reg} + kpg_pkg::CNT_W'(1);
    assign rem_dec  = rem_reg[i_reg] - kpg_pkg::CNT_W'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == kpg_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{kpg_pkg::PAD_W{1'b0}}, out_val_reg, out_idx_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= kpg_pkg::CNT_W'(kpg_pkg::MAX_ITEMS);
            pick_count_reg <= kpg_pkg::CNT_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                kpg_pkg::REG_ITEM_COUNT: item_count_reg <= cfg_data;
                kpg_pkg::REG_PICK_COUNT: pick_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // index memory, unwritten entries read as identity
    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata_reg <= ord_valid_reg[ord_raddr] ? ord_mem[ord_raddr] : ord_raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ord_clear) begin
            ord_valid_reg <= '0;
        end else if (ord_we) begin
            ord_valid_reg[ord_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pool_we) begin
            pool_mem[s_tdata[kpg_pkg::IDX_W-1:0]] <= s_tdata[kpg_pkg::IDX_W +: kpg_pkg::ELEM_WIDTH];
        end
        if (pool_re) begin
            pool_rdata_reg <= pool_mem[pool_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kpg_pkg::ST_IDLE;
            first_reg     <= 1'b1;
            exh_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < kpg_pkg::MAX_ITEMS; e++) begin
                rem_reg[e] <= kpg_pkg::rem_init(kpg_pkg::CNT_W'(kpg_pkg::MAX_ITEMS), e);
            end
        end else begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            exh_reg       <= exh_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
        i_reg        <= i_next;
        j_reg        <= j_next;
        p_reg        <= p_next;
        ptr_reg      <= ptr_next;
        tmp_reg      <= tmp_next;
        idx_reg      <= idx_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    always_comb begin
        state_next     = state_reg;
        first_next     = first_reg;
        exh_next       = exh_reg;
        rem_next       = rem_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        ptr_next       = ptr_reg;
        tmp_next       = tmp_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        ord_we         = 1'b0;
        ord_clear      = 1'b0;
        ord_waddr      = '0;
        ord_wdata      = '0;
        ord_raddr      = '0;
        pool_we        = 1'b0;
        pool_re        = 1'b0;
        pool_raddr     = '0;

        case (state_reg)
            kpg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        kpg_pkg::OP_LOAD: pool_we = 1'b1;
                        kpg_pkg::OP_RESTART: begin
                            ord_clear  = 1'b1;
                            first_next = 1'b1;
                            exh_next   = 1'b0;
                            for (int e = 0; e < kpg_pkg::MAX_ITEMS; e++) begin
                                rem_next[e] = kpg_pkg::rem_init(n_eff, e);
                            end
                        end
                        kpg_pkg::OP_NEXT: begin
                            if (n_eff == '0 || pick_count_reg == '0 ||
                                pick_count_reg > n_eff || exh_reg) begin
                                state_next = kpg_pkg::ST_DONE;
                            end else if (first_reg) begin
                                first_next = 1'b0;
                                p_next     = '0;
                                state_next = kpg_pkg::ST_EMIT_ORD;
                            end else begin
                                i_next     = k_dec[kpg_pkg::IDX_W-1:0];
                                state_next = kpg_pkg::ST_ADV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            kpg_pkg::ST_ADV: begin
                rem_next[i_reg] = rem_dec;
                if (rem_dec != '0) begin
                    p_next = '0;
                    if (rem_dec <= n_eff) begin
                        j_next     = kpg_pkg::idx_t'(n_eff - rem_dec);
                        state_next = kpg_pkg::ST_SWP_RD_A;
                    end else begin
                        state_next = kpg_pkg::ST_EMIT_ORD;
                    end
                end else begin
                    rem_next[i_reg] = n_eff - {1'b0, i_reg};
                    state_next      = kpg_pkg::ST_ROT_RD0;
                end
            end
            kpg_pkg::ST_SWP_RD_A: begin
                ord_raddr  = i_reg;
                state_next = kpg_pkg::ST_SWP_RD_B;
            end
            kpg_pkg::ST_SWP_RD_B: begin
                ord_raddr  = j_reg;
                tmp_next   = ord_rdata_reg;
                state_next = kpg_pkg::ST_SWP_WR_A;
            end
            kpg_pkg::ST_SWP_WR_A: begin
                ord_we     = 1'b1;
                ord_waddr  = i_reg;
                ord_wdata  = ord_rdata_reg;
                state_next = kpg_pkg::ST_SWP_WR_B;
            end
            kpg_pkg::ST_SWP_WR_B: begin
                ord_we     = 1'b1;
                ord_waddr  = j_reg;
                ord_wdata  = tmp_reg;
                state_next = kpg_pkg::ST_EMIT_ORD;
            end
            kpg_pkg::ST_ROT_RD0: begin
                ord_raddr  = i_reg;
                ptr_next   = {1'b0, i_reg} + kpg_pkg::CNT_W'(1);
                state_next = kpg_pkg::ST_ROT_TMP;
            end
            kpg_pkg::ST_ROT_TMP: begin
                tmp_next   = ord_rdata_reg;
                state_next = kpg_pkg::ST_ROT_RD;
            end
            kpg_pkg::ST_ROT_RD: begin
                if (ptr_reg < n_eff) begin
                    ord_raddr  = ptr_reg[kpg_pkg::IDX_W-1:0];
                    state_next = kpg_pkg::ST_ROT_WR;
                end else begin
                    state_next = kpg_pkg::ST_ROT_LAST;
                end
            end
            kpg_pkg::ST_ROT_WR: begin
                ord_we     = 1'b1;
                ord_waddr  = ptr_dec[kpg_pkg::IDX_W-1:0];
                ord_wdata  = ord_rdata_reg;
                ptr_next   = ptr_reg + kpg_pkg::CNT_W'(1);
                state_next = kpg_pkg::ST_ROT_RD;
            end
            kpg_pkg::ST_ROT_LAST: begin
                ord_we    = 1'b1;
                ord_waddr = n_dec[kpg_pkg::IDX_W-1:0];
                ord_wdata = tmp_reg;
                if (i_reg == '0) begin
                    exh_next   = 1'b1;
                    state_next = kpg_pkg::ST_DONE;
                end else begin
                    i_next     = i_reg - kpg_pkg::IDX_W'(1);
                    state_next = kpg_pkg::ST_ADV;
                end
            end
            kpg_pkg::ST_EMIT_ORD: begin
                ord_raddr  = p_reg;
                state_next = kpg_pkg::ST_EMIT_POOL;
            end
            kpg_pkg::ST_EMIT_POOL: begin
                pool_re    = 1'b1;
                pool_raddr = ord_rdata_reg;
                idx_next   = ord_rdata_reg;
                state_next = kpg_pkg::ST_EMIT_OUT;
            end
            kpg_pkg::ST_EMIT_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_val_next   = pool_rdata_reg;
                    out_last_next  = (p_plus == pick_count_reg);
                    out_done_next  = 1'b0;
                    if (p_plus == pick_count_reg) begin
                        state_next = kpg_pkg::ST_IDLE;
                    end else begin
                        p_next     = p_plus[kpg_pkg::IDX_W-1:0];
                        state_next = kpg_pkg::ST_EMIT_ORD;
                    end
                end
            end
            kpg_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_val_next   = '0;
                    out_last_next  = 1'b0;
                    out_done_next  = 1'b1;
                    state_next     = kpg_pkg::ST_IDLE;
                end
            end
            default: state_next = kpg_pkg::ST_IDLE;
        endcase
    end

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("done transaction carries row data");

    a_exh_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        exh_reg |-> !first_reg)
        else $error("exhausted with first row still pending");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == kpg_pkg::OP_RESTART) |=> (!exh_reg && first_reg))
        else $error("restart did not rearm the sequence");

    a_rot_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kpg_pkg::ST_ROT_WR) |-> (ptr_reg != '0))
        else $error("rotate write below entry zero");

endmodule

// ===== tb/kpg_checker.sv =====
`timescale 1ns / 1ps

module kpg_checker
    import kpg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]    s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    input  logic               m_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [CNT_W-1:0]   cfg_data,
    output int                 errors,
    output int                 pending,
    output int                 rows_seen,
    output int                 dones_seen
);

    typedef struct packed {
        idx_t  idx;
        elem_t value;
        logic  last;
        logic  done;
    } perm_pos_t;

    elem_t     pool      [MAX_ITEMS];
    idx_t      order     [MAX_ITEMS];
    cnt_t      remaining [MAX_ITEMS];
    logic      first_row;
    logic      exhausted;
    cnt_t      n_reg;
    cnt_t      k_reg;
    perm_pos_t row_q [$];

    function automatic int live_n();
        return (n_reg > MAX_ITEMS) ? MAX_ITEMS : int'(n_reg);
    endfunction

    function automatic void restart_seq();
        int n;
        n = live_n();
        for (int e = 0; e < MAX_ITEMS; e++) begin
            order[e]     = idx_t'(e);
            remaining[e] = (e < n) ? cnt_t'(n - e) : '0;
        end
        first_row = 1'b1;
        exhausted = 1'b0;
    endfunction

    function automatic void swap_order(input int a, input int b);
        idx_t t;
        t        = order[a];
        order[a] = order[b];
        order[b] = t;
    endfunction

    function automatic void push_row(input int k);
        perm_pos_t pos;
        for (int p = 0; p < k; p++) begin
            pos.idx   = order[p];
            pos.value = pool[order[p]];
            pos.last  = (p == k - 1);
            pos.done  = 1'b0;
            row_q.push_back(pos);
        end
    endfunction

    function automatic void push_done();
        perm_pos_t pos;
        pos      = '0;
        pos.done = 1'b1;
        row_q.push_back(pos);
    endfunction

    // cycles scheme: count down from the deepest level, swap on nonzero,
    // otherwise rotate the tail left by one and rearm the counter
    function automatic void next_perm();
        int n;
        int k;
        int c;
        n = live_n();
        k = int'(k_reg);
        if (n == 0 || k == 0 || k > n || exhausted) begin
            push_done();
            return;
        end
        if (first_row) begin
            first_row = 1'b0;
            push_row(k);
            return;
        end
        for (int i = k - 1; i >= 0; i--) begin
            c = (int'(remaining[i]) + 31) & 31;
            remaining[i] = cnt_t'(c);
            if (c != 0) begin
                if (c <= n)
                    swap_order(i, n - c);
                push_row(k);
                return;
            end
            for (int j = i + 1; j < n; j++)
                swap_order(j - 1, j);
            remaining[i] = cnt_t'(n - i);
        end
        exhausted = 1'b1;
        push_done();
    endfunction

    always @(posedge aclk) begin
        perm_pos_t got;
        perm_pos_t want;
        if (!aresetn) begin
            n_reg = 5'd16;
            k_reg = 5'd1;
            for (int e = 0; e < MAX_ITEMS; e++)
                pool[e] = '0;
            restart_seq();
            row_q.delete();
            errors     = 0;
            pending    = 0;
            rows_seen  = 0;
            dones_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.idx   = m_tdata[IDX_W-1:0];
                got.value = m_tdata[IDX_W +: ELEM_WIDTH];
                got.last  = m_tlast;
                got.done  = m_tuser;
                if (row_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got idx=%0d value=%h last=%b done=%b",
                             $time, got.idx, got.value, got.last, got.done);
                end else begin
                    want = row_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: result mismatch: expected idx=%0d value=%h last=%b done=%b",
                                 $time, want.idx, want.value, want.last, want.done);
                        $display("%0t:                  got      idx=%0d value=%h last=%b done=%b",
                                 $time, got.idx, got.value, got.last, got.done);
                    end
                    if (want.done)
                        dones_seen++;
                    else
                        rows_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ITEM_COUNT)
                    n_reg = cfg_data;
                else
                    k_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_LOAD:    pool[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: ELEM_WIDTH];
                    OP_RESTART: restart_seq();
                    OP_NEXT:    next_perm();
                    default:    ;
                endcase
            end
            pending = row_q.size();
        end
    end

endmodule

// ===== tb/tb_k_permutation_generator_core.sv =====
`timescale 1ns / 1ps

module tb_k_permutation_generator_core;
    import kpg_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam int              SETTLE_CYCLES = 1000;
    localparam int              PHASES        = 8;
    localparam int              PHASE_ITEMS   = 50;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]    s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [CNT_W-1:0]   cfg_data  = '0;

    int errors;
    int pending;
    int rows_seen;
    int dones_seen;
    int src_idle   = 0;
    int sink_stall = 0;
    int items_sent = 0;

    k_permutation_generator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kpg_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .rows_seen  (rows_seen),
        .dones_seen (dones_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("k_permutation_generator_core test failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    task automatic send(input logic [OP_W-1:0] op, input idx_t li, input elem_t lv);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= TDATA_W'({lv, li});
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic command(input logic [OP_W-1:0] op);
        send(op, idx_t'($urandom), elem_t'($urandom));
    endtask

    task automatic write_reg(input logic ri, input cnt_t val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // quiesce before any register write
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input cnt_t n, input cnt_t k);
        settle();
        write_reg(REG_ITEM_COUNT, n);
        write_reg(REG_PICK_COUNT, k);
    endtask

    initial begin
        int   n;
        int   k;
        int   r;
        elem_t v;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill the whole pool so no row ever reads an unwritten entry
        for (int e = 0; e < MAX_ITEMS; e++) begin
            case (e)
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'h5555_5555;
                3:       v = 32'hAAAA_AAAA;
                default: v = elem_t'($urandom);
            endcase
            send(OP_LOAD, idx_t'(e), v);
        end

        // reset settings: identity row, one advance, ignored opcode
        command(OP_NEXT);
        command(OP_NEXT);
        command(OP_UNUSED);

        // short sequence run to exhaustion and past it
        configure(5'd3, 5'd2);
        command(OP_RESTART);
        repeat (8) command(OP_NEXT);

        // empty sequences
        configure(5'd3, 5'd0);
        command(OP_NEXT);
        configure(5'd3, 5'd4);
        command(OP_NEXT);
        configure(5'd0, 5'd1);
        command(OP_NEXT);

        // oversized n, full-length rows
        configure(5'd31, 5'd16);
        command(OP_RESTART);
        repeat (3) command(OP_NEXT);

        // settings changed without restart, counter wraps at level 3
        configure(5'd2, 5'd1);
        command(OP_RESTART);
        command(OP_NEXT);
        configure(5'd4, 5'd4);
        repeat (3) command(OP_NEXT);

        configure(5'd1, 5'd1);
        command(OP_RESTART);
        repeat (2) command(OP_NEXT);

        for (int ph = 0; ph < PHASES; ph++) begin
            r = $urandom_range(9);
            n = (r == 0) ? 16 : (r == 1) ? 1 : $urandom_range(6, 2);
            k = $urandom_range(n + 1, 0);
            configure(cnt_t'(n), cnt_t'(k));
            case (ph % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 49; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 49; end
                default: begin src_idle = 25; sink_stall = 25; end
            endcase
            if ($urandom_range(3) != 0)
                command(OP_RESTART);
            for (int it = 0; it < PHASE_ITEMS; it++) begin
                r = $urandom_range(99);
                if (r < 70)
                    command(OP_NEXT);
                else if (r < 85)
                    send(OP_LOAD, idx_t'($urandom), elem_t'($urandom));
                else if (r < 95)
                    command(OP_RESTART);
                else
                    command(OP_UNUSED);
            end
        end

        settle();
        $display("Sent %0d input transactions across directed cases and %0d mixed-pressure phases",
                 items_sent, PHASES);
        $display("Compared %0d row positions and %0d done results", rows_seen, dones_seen);
        if (errors == 0)
            $display("k_permutation_generator_core test passed");
        else
            $display("k_permutation_generator_core test failed");
        $finish;
    end

endmodule

// ===== k_permutation_generator_core.f =====
sv/kpg_pkg.sv
sv/k_permutation_generator_core.sv
tb/kpg_checker.sv
tb/tb_k_permutation_generator_core.sv
